@@ rtl/triangle_cube_overlap_test_defines.svh @@
// Assertion macros shared by the triangle and cube overlap test.
`ifndef TRIANGLE_CUBE_OVERLAP_TEST_DEFINES_SVH
`define TRIANGLE_CUBE_OVERLAP_TEST_DEFINES_SVH

// Condition implies consequence at the same clock edge.
`define TCO_ASSERT_SAME(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Condition implies consequence at the next clock edge.
`define TCO_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tco_pkg.sv @@
// Package with shared constants of the triangle and cube overlap test.
`timescale 1ns / 1ps
package tco_pkg;
   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int NUM_AXES        = 9;
   localparam int NUM_VERTS       = 3;
endpackage

@@ rtl/triangle_cube_overlap_test.sv @@
// Top level of the pipelined triangle against unit cube overlap test.
`timescale 1ns / 1ps
// Takes one triangle per cycle while the pipeline advances and reports whether it
// touches or crosses the cube of half-size one half centered at the origin, with
// exact integer math. The pipeline is seven register stages deep. Throughput
// is one triangle per clock when the output side does not stall. The deepest
// logic per stage is one of three things: a multiplier of about COORD_WIDTH+1
// by COORD_WIDTH bits, a chain of wide compares, or a wide sum of six terms.
// The whole pipeline advances together. It holds whenever the result register
// is full and not taken, and req_ready is low exactly then. Results come out
// in input order.
`include "triangle_cube_overlap_test_defines.svh"
module triangle_cube_overlap_test #(
   parameter int COORD_WIDTH = tco_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = tco_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_v0_x,
   input  logic signed [COORD_WIDTH-1:0] req_v0_y,
   input  logic signed [COORD_WIDTH-1:0] req_v0_z,
   input  logic signed [COORD_WIDTH-1:0] req_v1_x,
   input  logic signed [COORD_WIDTH-1:0] req_v1_y,
   input  logic signed [COORD_WIDTH-1:0] req_v1_z,
   input  logic signed [COORD_WIDTH-1:0] req_v2_x,
   input  logic signed [COORD_WIDTH-1:0] req_v2_y,
   input  logic signed [COORD_WIDTH-1:0] req_v2_z,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_overlaps
);
   localparam int C  = COORD_WIDTH;
   localparam int NA = tco_pkg::NUM_AXES;
   localparam int NV = tco_pkg::NUM_VERTS;

   logic en;
   logic signed [C-1:0] v_in [NV][3];
   logic valid_s3, bb_ok_s3;
   logic signed [2*C:0]   m1_s3 [NA][NV];
   logic signed [2*C:0]   m2_s3 [NA][NV];
   logic [C+1:0]          rsum_s3 [NA];
   logic signed [2*C+1:0] np1_s3 [3], np2_s3 [3];
   logic signed [2*C-1:0] cp1_s3 [3], cp2_s3 [3];
   logic signed [C-1:0]   v0_s3 [3];

   // The pipeline moves whenever the result register is empty or being taken.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign v_in[0][0] = req_v0_x;
   assign v_in[0][1] = req_v0_y;
   assign v_in[0][2] = req_v0_z;
   assign v_in[1][0] = req_v1_x;
   assign v_in[1][1] = req_v1_y;
   assign v_in[1][2] = req_v1_z;
   assign v_in[2][0] = req_v2_x;
   assign v_in[2][1] = req_v2_y;
   assign v_in[2][2] = req_v2_z;

   tco_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .en(en), .req_valid(req_valid), .v_in(v_in),
      .valid_s3(valid_s3), .m1_s3(m1_s3), .m2_s3(m2_s3), .rsum_s3(rsum_s3),
      .np1_s3(np1_s3), .np2_s3(np2_s3), .cp1_s3(cp1_s3), .cp2_s3(cp2_s3),
      .v0_s3(v0_s3), .bb_ok_s3(bb_ok_s3)
   );

   tco_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .en(en), .valid_s3(valid_s3),
      .m1_s3(m1_s3), .m2_s3(m2_s3), .rsum_s3(rsum_s3),
      .np1_s3(np1_s3), .np2_s3(np2_s3), .cp1_s3(cp1_s3), .cp2_s3(cp2_s3),
      .v0_s3(v0_s3), .bb_ok_s3(bb_ok_s3),
      .rsp_valid(rsp_valid), .rsp_overlaps(rsp_overlaps)
   );

   // A waiting result freezes the pipeline, so no new transfer may enter.
   `TCO_ASSERT_SAME(a_stall_blocks_input, rsp_valid && !rsp_ready, !req_ready, "input taken while stalled")
   // A result can only appear once the pipeline has advanced.
   `TCO_ASSERT_NEXT(a_result_needs_advance, !rsp_valid && !req_ready, !rsp_valid, "result without advance")
endmodule

@@ rtl/tco_front.sv @@
// Front half of the pipeline: input register, edges and box test, all products.
`timescale 1ns / 1ps
module tco_front #(
   parameter int COORD_WIDTH = tco_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = tco_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic req_valid,
   input  logic signed [COORD_WIDTH-1:0] v_in [tco_pkg::NUM_VERTS][3],
   output logic valid_s3,
   output logic signed [2*COORD_WIDTH:0] m1_s3 [tco_pkg::NUM_AXES][tco_pkg::NUM_VERTS],
   output logic signed [2*COORD_WIDTH:0] m2_s3 [tco_pkg::NUM_AXES][tco_pkg::NUM_VERTS],
   output logic [COORD_WIDTH+1:0] rsum_s3 [tco_pkg::NUM_AXES],
   output logic signed [2*COORD_WIDTH+1:0] np1_s3 [3],
   output logic signed [2*COORD_WIDTH+1:0] np2_s3 [3],
   output logic signed [2*COORD_WIDTH-1:0] cp1_s3 [3],
   output logic signed [2*COORD_WIDTH-1:0] cp2_s3 [3],
   output logic signed [COORD_WIDTH-1:0] v0_s3 [3],
   output logic bb_ok_s3
);
   localparam int C   = COORD_WIDTH;
   localparam int EW  = C + 1;
   localparam int PW  = 2 * C + 1;
   localparam int NPW = 2 * C + 2;
   localparam int XPW = 2 * C;
   localparam int BW  = C + FRAC_BITS + 1;
   localparam int AW  = C + 2;
   localparam int NA  = tco_pkg::NUM_AXES;
   localparam int NV  = tco_pkg::NUM_VERTS;

   logic                 valid_s1_ff, valid_s2_ff, valid_s3_ff;
   logic signed [C-1:0]  v_s1_ff [NV][3];
   logic signed [C-1:0]  v_s2_ff [NV][3];
   logic signed [EW-1:0] f_s2_in [3][3];
   logic signed [EW-1:0] f_s2_ff [3][3];
   logic                 bb_ok_s2_in, bb_ok_s2_ff, bb_ok_s3_ff;
   logic signed [PW-1:0] m1_s3_in [NA][NV];
   logic signed [PW-1:0] m2_s3_in [NA][NV];
   logic signed [PW-1:0] m1_s3_ff [NA][NV];
   logic signed [PW-1:0] m2_s3_ff [NA][NV];
   logic [AW-1:0]        rsum_s3_in [NA];
   logic [AW-1:0]        rsum_s3_ff [NA];
   logic signed [NPW-1:0] np1_s3_in [3], np2_s3_in [3], np1_s3_ff [3], np2_s3_ff [3];
   logic signed [XPW-1:0] cp1_s3_in [3], cp2_s3_in [3], cp1_s3_ff [3], cp2_s3_ff [3];
   logic signed [C-1:0]  v0_s3_ff [3];

   // Edges and the bounding box test on the registered vertices.
   always_comb begin
      logic signed [BW-1:0] mn, mx, half;
      half = BW'(1) <<< (FRAC_BITS - 1);
      bb_ok_s2_in = 1'b1;
      for (int e = 0; e < 3; e++) begin
         for (int k = 0; k < 3; k++) begin
            f_s2_in[e][k] = EW'(v_s1_ff[(e == 2) ? 0 : e + 1][k]) - EW'(v_s1_ff[e][k]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         mn = BW'(v_s1_ff[0][k]);
         mx = mn;
         for (int e = 1; e < 3; e++) begin
            if (BW'(v_s1_ff[e][k]) < mn) mn = BW'(v_s1_ff[e][k]);
            if (BW'(v_s1_ff[e][k]) > mx) mx = BW'(v_s1_ff[e][k]);
         end
         if ((mx < -half) || (mn > half)) bb_ok_s2_in = 1'b0;
      end
   end

   // Products of every edge-cross axis with every vertex, plus normal and triple product.
   always_comb begin
      logic signed [AW-1:0] ap, aq;
      int p, q;
      for (int ax = 0; ax < 3; ax++) begin
         p = (ax == 2) ? 0 : ax + 1;
         q = (ax == 0) ? 2 : ax - 1;
         for (int e = 0; e < 3; e++) begin
            ap = AW'(f_s2_ff[e][p]);
            aq = AW'(f_s2_ff[e][q]);
            if (ap[AW-1]) ap = -ap;
            if (aq[AW-1]) aq = -aq;
            rsum_s3_in[ax*3+e] = ap + aq;
            for (int i = 0; i < NV; i++) begin
               m1_s3_in[ax*3+e][i] = PW'(f_s2_ff[e][p]) * PW'(v_s2_ff[i][q]);
               m2_s3_in[ax*3+e][i] = PW'(f_s2_ff[e][q]) * PW'(v_s2_ff[i][p]);
            end
         end
         np1_s3_in[ax] = NPW'(f_s2_ff[0][p]) * NPW'(f_s2_ff[2][q]);
         np2_s3_in[ax] = NPW'(f_s2_ff[0][q]) * NPW'(f_s2_ff[2][p]);
         cp1_s3_in[ax] = XPW'(v_s2_ff[1][p]) * XPW'(v_s2_ff[2][q]);
         cp2_s3_in[ax] = XPW'(v_s2_ff[1][q]) * XPW'(v_s2_ff[2][p]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
      end else if (en) begin
         valid_s1_ff <= req_valid;
         valid_s2_ff <= valid_s1_ff;
         valid_s3_ff <= valid_s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_s1_ff     <= v_in;
         v_s2_ff     <= v_s1_ff;
         f_s2_ff     <= f_s2_in;
         bb_ok_s2_ff <= bb_ok_s2_in;
         m1_s3_ff    <= m1_s3_in;
         m2_s3_ff    <= m2_s3_in;
         rsum_s3_ff  <= rsum_s3_in;
         np1_s3_ff   <= np1_s3_in;
         np2_s3_ff   <= np2_s3_in;
         cp1_s3_ff   <= cp1_s3_in;
         cp2_s3_ff   <= cp2_s3_in;
         v0_s3_ff    <= v_s2_ff[0];
         bb_ok_s3_ff <= bb_ok_s2_ff;
      end
   end

   assign valid_s3 = valid_s3_ff;
   assign m1_s3    = m1_s3_ff;
   assign m2_s3    = m2_s3_ff;
   assign rsum_s3  = rsum_s3_ff;
   assign np1_s3   = np1_s3_ff;
   assign np2_s3   = np2_s3_ff;
   assign cp1_s3   = cp1_s3_ff;
   assign cp2_s3   = cp2_s3_ff;
   assign v0_s3    = v0_s3_ff;
   assign bb_ok_s3 = bb_ok_s3_ff;
endmodule

@@ rtl/tco_back.sv @@
// Back half of the pipeline: projections, axis decisions, plane distance, result register.
`timescale 1ns / 1ps
module tco_back #(
   parameter int COORD_WIDTH = tco_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = tco_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic valid_s3,
   input  logic signed [2*COORD_WIDTH:0] m1_s3 [tco_pkg::NUM_AXES][tco_pkg::NUM_VERTS],
   input  logic signed [2*COORD_WIDTH:0] m2_s3 [tco_pkg::NUM_AXES][tco_pkg::NUM_VERTS],
   input  logic [COORD_WIDTH+1:0] rsum_s3 [tco_pkg::NUM_AXES],
   input  logic signed [2*COORD_WIDTH+1:0] np1_s3 [3],
   input  logic signed [2*COORD_WIDTH+1:0] np2_s3 [3],
   input  logic signed [2*COORD_WIDTH-1:0] cp1_s3 [3],
   input  logic signed [2*COORD_WIDTH-1:0] cp2_s3 [3],
   input  logic signed [COORD_WIDTH-1:0] v0_s3 [3],
   input  logic bb_ok_s3,
   output logic rsp_valid,
   output logic rsp_overlaps
);
   localparam int C   = COORD_WIDTH;
   localparam int SW  = 2 * C + 2;
   localparam int NW  = 2 * C + 3;
   localparam int XW  = 2 * C + 1;
   localparam int HW  = XW - C;
   localparam int DPW = 2 * C + 1;
   localparam int DW  = 3 * C + 4;
   localparam int KW  = 2 * C + FRAC_BITS + 4;
   localparam int TW  = 3 * C + FRAC_BITS + 4;
   localparam int AW  = C + 2;
   localparam int NA  = tco_pkg::NUM_AXES;
   localparam int NV  = tco_pkg::NUM_VERTS;

   logic valid_s4_ff, valid_s5_ff, valid_s6_ff, rsp_valid_ff, rsp_overlaps_ff;
   logic signed [SW-1:0] proj_s4_in [NA][NV];
   logic signed [SW-1:0] proj_s4_ff [NA][NV];
   logic signed [NW-1:0] n_s4_in [3], n_s4_ff [3];
   logic signed [XW-1:0] c_s4_in [3], c_s4_ff [3];
   logic [AW-1:0]        rsum_s4_ff [NA];
   logic signed [C-1:0]  v0_s4_ff [3];
   logic                 bb_ok_s4_ff, bb_ok_s5_ff, bb_ok_s6_ff;
   logic                 sep_s5_in, sep_s5_ff, sep_s6_ff;
   logic signed [DPW-1:0] dl_s5_in [3], dh_s5_in [3], dl_s5_ff [3], dh_s5_ff [3];
   logic [NW+1:0]        nsum_s5_in, nsum_s5_ff;
   logic [DW-1:0]        dabs_s6_in, dabs_s6_ff;
   logic [TW-1:0]        rn_s6_ff;
   logic                 ok_s7_in;

   // Stage 4: projections, normal and triple-product components.
   always_comb begin
      for (int j = 0; j < NA; j++) begin
         for (int i = 0; i < NV; i++) begin
            proj_s4_in[j][i] = SW'(m1_s3[j][i]) - SW'(m2_s3[j][i]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         n_s4_in[k] = NW'(np1_s3[k]) - NW'(np2_s3[k]);
         c_s4_in[k] = XW'(cp1_s3[k]) - XW'(cp2_s3[k]);
      end
   end

   // Stage 5: separation on each edge axis; split products of the plane distance; normal sum.
   always_comb begin
      logic signed [KW-1:0] r, lo, hi, p;
      logic signed [HW-1:0] chi, clo;
      logic signed [NW+1:0] na;
      sep_s5_in  = 1'b0;
      nsum_s5_in = '0;
      for (int j = 0; j < NA; j++) begin
         r  = KW'(rsum_s4_ff[j]) << (FRAC_BITS - 1);
         lo = KW'(proj_s4_ff[j][0]);
         hi = lo;
         for (int i = 1; i < NV; i++) begin
            p = KW'(proj_s4_ff[j][i]);
            if (p < lo) lo = p;
            if (p > hi) hi = p;
         end
         if ((r < lo) || (hi < -r)) sep_s5_in = 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
         clo = {1'b0, c_s4_ff[k][C-1:0]};
         chi = c_s4_ff[k][XW-1:C];
         dl_s5_in[k] = DPW'(clo) * DPW'(v0_s4_ff[k]);
         dh_s5_in[k] = DPW'(chi) * DPW'(v0_s4_ff[k]);
         na = (NW+2)'(n_s4_ff[k]);
         if (na[NW+1]) na = -na;
         nsum_s5_in = nsum_s5_in + na;
      end
   end

   // Stage 6: plane distance magnitude.
   always_comb begin
      logic signed [DW-1:0] d;
      d = '0;
      for (int k = 0; k < 3; k++) begin
         d = d + (DW'(dh_s5_ff[k]) <<< C) + DW'(dl_s5_ff[k]);
      end
      dabs_s6_in = d[DW-1] ? -d : d;
   end

   assign ok_s7_in = !sep_s6_ff && bb_ok_s6_ff && (rn_s6_ff >= TW'(dabs_s6_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s4_ff  <= 1'b0;
         valid_s5_ff  <= 1'b0;
         valid_s6_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_s4_ff  <= valid_s3;
         valid_s5_ff  <= valid_s4_ff;
         valid_s6_ff  <= valid_s5_ff;
         rsp_valid_ff <= valid_s6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         proj_s4_ff      <= proj_s4_in;
         n_s4_ff         <= n_s4_in;
         c_s4_ff         <= c_s4_in;
         rsum_s4_ff      <= rsum_s3;
         v0_s4_ff        <= v0_s3;
         bb_ok_s4_ff     <= bb_ok_s3;
         sep_s5_ff       <= sep_s5_in;
         dl_s5_ff        <= dl_s5_in;
         dh_s5_ff        <= dh_s5_in;
         nsum_s5_ff      <= nsum_s5_in;
         bb_ok_s5_ff     <= bb_ok_s4_ff;
         dabs_s6_ff      <= dabs_s6_in;
         rn_s6_ff        <= TW'(nsum_s5_ff) << (FRAC_BITS - 1);
         sep_s6_ff       <= sep_s5_ff;
         bb_ok_s6_ff     <= bb_ok_s5_ff;
         rsp_overlaps_ff <= ok_s7_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_overlaps = rsp_overlaps_ff;
endmodule
